@@ rtl/mexp_pkg.sv @@
// Package for the modular exponentiation unit.
// Register index codes and the multiplier control/status types. No dependencies.
package mexp_pkg;

  // Configuration register indexes (word address divided by the register stride)
  localparam logic REG_EXPONENT = 1'b0;
  localparam logic REG_MODULUS  = 1'b1;

  // Control from the exponent sequencer to the multiplier
  typedef struct packed {
    logic start;
  } mul_ctrl_t;

  // Status back from the multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

@@ rtl/mexp_cell.sv @@
// One bit cell of the multiplier-operand chain.
// Loads a bit in parallel or takes its lower neighbor's bit. Depends on nothing.
module mexp_cell (
  input  logic clk_i,
  input  logic load_i,
  input  logic shift_i,
  input  logic load_bit_i,
  input  logic prev_bit_i,
  output logic bit_o
);

  logic bit_q, bit_d;

  always_comb begin
    bit_d = bit_q;
    if (load_i) begin
      bit_d = load_bit_i;
    end else if (shift_i) begin
      bit_d = prev_bit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
  end

  assign bit_o = bit_q;

endmodule

@@ rtl/mexp_mulmod.sv @@
// Interleaved MSB-first modular multiplier: p = x * y mod m, with x < m.
// One operand bit per cycle from a chain of mexp_cell; uses mexp_pkg.
module mexp_mulmod import mexp_pkg::*; #(
  parameter int WORD_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mul_ctrl_t            ctrl_i,
  input  logic [WORD_BITS-1:0] x_i,
  input  logic [WORD_BITS-1:0] y_i,
  input  logic [WORD_BITS-1:0] m_i,
  output mul_stat_t            stat_o,
  output logic [WORD_BITS-1:0] p_o
);

  localparam int CW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [CW-1:0] LAST = CW'(WORD_BITS - 1);

  logic [WORD_BITS-1:0] chain;
  logic [WORD_BITS-1:0] acc_q, acc_d, x_q, m_q;
  logic [CW-1:0]        ctr_q, ctr_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic                 shift;
  logic [WORD_BITS:0]   dbl, dbl_red, sum;
  logic [WORD_BITS-1:0] sum_red;

  assign shift = busy_q;

  // Operand chain: bits move toward the top cell, which feeds the datapath
  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    mexp_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (ctrl_i.start),
      .shift_i    (shift),
      .load_bit_i (y_i[i]),
      .prev_bit_i ((i == 0) ? 1'b0 : chain[(i == 0) ? 0 : i-1]),
      .bit_o      (chain[i])
    );
  end

  // acc = (2*acc + bit*x) mod m, both halves reduced by one compare/subtract
  always_comb begin
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    sum     = dbl_red + {1'b0, (chain[WORD_BITS-1] ? x_q : '0)};
    sum_red = (sum >= {1'b0, m_q}) ? WORD_BITS'(sum - {1'b0, m_q})
                                   : sum[WORD_BITS-1:0];
  end

  always_comb begin
    acc_d  = acc_q;
    ctr_d  = ctr_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      acc_d  = '0;
      ctr_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = sum_red;
      ctr_d = ctr_q + 1'b1;
      if (ctr_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ctr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ctr_q  <= ctr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctrl_i.start) begin
      x_q <= x_i;
      m_q <= m_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign p_o         = acc_q;

endmodule

@@ rtl/modular_exponentiation_unit.sv @@
// Top level of the modular exponentiation unit: base^exponent mod modulus.
// Uses mexp_pkg, mexp_mulmod (and through it mexp_cell).
//
//  channel   | dir | handshake                 | payload
//  s_axis    | in  | s_axis_tvalid/tready      | tdata[W-1:0] base
//  m_axis    | out | m_axis_tvalid/tready      | tdata[W-1:0] result
//  apb       | in  | psel, penable, pready     | 0x0 exponent, 0x4 modulus (0x8 if W>32)
//
// One item at a time. Each modular product holds the sequencer through its start,
// W bit steps and done. An item runs through accept, base reduction, a scan past
// the leading zero bits of the exponent, then per significant bit a square, a
// multiply if the bit is set and a step, then a final state. Exponent or modulus
// zero: straight from accept to the final state.
// A finished result waits in the output register; the next base is taken
// meanwhile, and the sequencer stalls only if a second result is ready first.
// Reset is asynchronous, active low; registers go to exponent 0, modulus 2.
module modular_exponentiation_unit import mexp_pkg::*; #(
  parameter int WORD_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // base input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [((WORD_BITS+7)/8)*8-1:0] s_axis_tdata,  // [W-1:0] base
  // result output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [((WORD_BITS+7)/8)*8-1:0] m_axis_tdata,  // [W-1:0] result
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [((WORD_BITS > 32) ? 4 : 3)-1:0] paddr,
  input  logic [((WORD_BITS > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((WORD_BITS > 32) ? 64 : 32)-1:0] prdata,
  output logic                 pready
);

  localparam int TDW = ((WORD_BITS + 7) / 8) * 8;
  localparam int AW  = (WORD_BITS > 32) ? 4 : 3;
  localparam int DW  = (WORD_BITS > 32) ? 64 : 32;
  localparam int IW  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [IW-1:0] TOP_BIT = IW'(WORD_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_REDUCE, S_SCAN, S_SQR, S_MUL, S_NEXT, S_FIN
  } state_e;

  state_e               state_q;
  logic [WORD_BITS-1:0] exp_q, mod_q;
  logic [WORD_BITS-1:0] base_q, z_q, res_q, out_q;
  logic [IW-1:0]        idx_q;
  logic                 out_vld_q;
  mul_ctrl_t            mctl_q;
  mul_stat_t            mstat;
  logic [WORD_BITS-1:0] mul_x, mul_y, mul_p, one_m;
  logic                 cfg_wr, reg_sel, s_fire;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[AW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
      mod_q <= WORD_BITS'(2);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_EXPONENT: exp_q <= pwdata[WORD_BITS-1:0];
        REG_MODULUS:  mod_q <= pwdata[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_EXPONENT: prdata[WORD_BITS-1:0] = exp_q;
      REG_MODULUS:  prdata[WORD_BITS-1:0] = mod_q;
      default: ;
    endcase
  end

  // 1 mod m: zero when the modulus is one
  assign one_m = (mod_q == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

  // ---------------- multiplier ----------------
  // Base reduction is the product 1 * base, so every later operand is below m
  always_comb begin
    mul_x = z_q;
    mul_y = z_q;
    case (state_q)
      S_REDUCE: begin
        mul_x = one_m;
        mul_y = base_q;
      end
      S_MUL:   mul_y = base_q;
      default: ;
    endcase
  end

  mexp_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mctl_q),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .m_i    (mod_q),
    .stat_o (mstat),
    .p_o    (mul_p)
  );

  // ---------------- sequencer ----------------
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mctl_q.start <= 1'b0;
      out_vld_q    <= 1'b0;
      idx_q        <= '0;
      base_q       <= '0;
      z_q          <= '0;
      res_q        <= '0;
      out_q        <= '0;
    end else begin
      mctl_q.start <= 1'b0;
      // output register: load a finished item or drop an accepted one
      if (state_q == S_FIN && (!out_vld_q || m_axis_tready)) begin
        out_q     <= res_q;
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            base_q <= s_axis_tdata[WORD_BITS-1:0];
            idx_q  <= TOP_BIT;
            if (mod_q == '0) begin
              res_q   <= '0;
              state_q <= S_FIN;
            end else if (exp_q == '0) begin
              res_q   <= WORD_BITS'(1);
              state_q <= S_FIN;
            end else begin
              mctl_q.start <= 1'b1;
              state_q      <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (mstat.done) begin
            base_q  <= mul_p;
            z_q     <= one_m;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          // skip leading zero bits, one per cycle
          if (exp_q[idx_q]) begin
            mctl_q.start <= 1'b1;
            state_q      <= S_SQR;
          end else begin
            idx_q <= idx_q - 1'b1;
          end
        end
        S_SQR: begin
          if (mstat.done) begin
            z_q <= mul_p;
            if (exp_q[idx_q]) begin
              mctl_q.start <= 1'b1;
              state_q      <= S_MUL;
            end else begin
              state_q <= S_NEXT;
            end
          end
        end
        S_MUL: begin
          if (mstat.done) begin
            z_q     <= mul_p;
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (idx_q == '0) begin
            res_q   <= z_q;
            state_q <= S_FIN;
          end else begin
            idx_q        <= idx_q - 1'b1;
            mctl_q.start <= 1'b1;
            state_q      <= S_SQR;
          end
        end
        S_FIN: begin
          if (!out_vld_q || m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TDW'(out_q);

endmodule

@@ rtl/mexp_checker.sv @@
// Port-level checks for modular_exponentiation_unit, bound to the top level.
// Depends on the top level's ports and its TDW width only.
module mexp_checker #(
  parameter int TDW = 16
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           s_axis_tvalid,
  input logic           s_axis_tready,
  input logic           m_axis_tvalid,
  input logic           m_axis_tready,
  input logic [TDW-1:0] m_axis_tdata,
  input logic           pready
);

  // one item in flight: input closes right after a base is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still ready after accepting a base");

  // a result never appears in the cycle right after a base is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result raised too early");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind modular_exponentiation_unit mexp_checker #(.TDW(TDW)) u_mexp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

@@ tb/modular_exponentiation_unit_checker.sv @@
// Result checker for the modular exponentiation unit: tracks register writes,
// predicts base^exponent mod modulus per accepted base and compares results.
// Depends on mexp_pkg for the register index codes.
module modular_exponentiation_unit_checker import mexp_pkg::*; (
  input  logic        clk_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] exp_q = 16'd0;
  logic [15:0] mod_q = 16'd2;
  logic [15:0] result_q[$];
  int          fails = 0;

  // Left-to-right square and multiply; the accumulator starts at 1 unreduced.
  function automatic logic [15:0] power_mod(logic [15:0] b, logic [15:0] e,
                                            logic [15:0] m);
    logic [31:0] z;
    bit          seen;
    z = 32'd1;
    seen = 0;
    if (m == 16'd0) return 16'd0;
    for (int i = 15; i >= 0; i--) begin
      if (e[i]) seen = 1;
      if (seen) begin
        z = (z * z) % m;
        if (e[i]) z = (z * ({16'd0, b} % m)) % m;
      end
    end
    return z[15:0];
  endfunction

  always @(posedge clk_i) begin
    if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_MODULUS) mod_q <= pwdata[15:0];
      else exp_q <= pwdata[15:0];
    end
    if (s_axis_tvalid && s_axis_tready)
      result_q = {result_q, power_mod(s_axis_tdata, exp_q, mod_q)};
    if (m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        fails++;
        $display("%t: unexpected result %h", $time, m_axis_tdata);
      end else begin
        logic [15:0] want;
        want = result_q.pop_front();
        if (want !== m_axis_tdata) begin
          fails++;
          $display("%t: result expected %h actual %h", $time, want, m_axis_tdata);
        end
      end
    end
  end

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();
endmodule

@@ tb/modular_exponentiation_unit_tb.sv @@
// Testbench top for the modular exponentiation unit: drives bases and register
// writes, stalls the result side, and reports the verdict.
// Depends on modular_exponentiation_unit and modular_exponentiation_unit_checker.
module modular_exponentiation_unit_tb import mexp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] base
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] result
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          burst_left = 0;
  bit          hold_req = 0;     // asks the receiver for one long hold-off

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  modular_exponentiation_unit #(.WORD_BITS(16)) DUT (.*);

  modular_exponentiation_unit_checker u_checker (
    .clk_i, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Register write: setup cycle, then access cycle; both at falling edges.
  task automatic write_reg(logic idx, logic [15:0] value);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {16'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Offer one base; gaps fall between bursts of random length.
  task automatic send_base(logic [15:0] b);
    @(negedge clk_i);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 1000 : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Phase end: drop valid, drain every result, then let the block settle.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Receiver: stall density is redrawn periodically; one long hold-off.
  initial begin
    int stall_pct, cyc;
    stall_pct = 0;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(negedge clk_i);
        hold_req = 0;
      end
      if (cyc % 200 == 0) stall_pct = ($urandom_range(0, 2)) * 40;
      cyc++;
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    logic [15:0] edge_bases[4];
    logic [15:0] dir_exp[6];
    logic [15:0] dir_mod[6];
    logic [15:0] e, m;
    edge_bases = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000};
    dir_exp    = '{16'd0, 16'hFFFF, 16'd0, 16'd5, 16'd3, 16'hFFFF};
    dir_mod    = '{16'd2, 16'hFFFF, 16'd1, 16'd1, 16'd0, 16'd2};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset values first, then extremes and the special moduli.
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        write_reg(REG_EXPONENT, dir_exp[p]);
        write_reg(REG_MODULUS, dir_mod[p]);
      end
      foreach (edge_bases[i]) send_base(edge_bases[i]);
      drain();
    end

    // Random phases; a few hit the extremes and degenerate moduli.
    for (int p = 0; p < 7; p++) begin
      e = 16'($urandom_range(0, 65535));
      m = 16'($urandom_range(2, 65535));
      case (p)
        1: e = 16'hFFFF;
        2: begin e = 16'h5555; m = 16'hAAAA; end
        3: m = 16'd0;
        4: m = 16'd1;
        5: e = 16'($urandom_range(1, 15));
        default: ;
      endcase
      write_reg(REG_EXPONENT, e);
      write_reg(REG_MODULUS, m);
      if (p == 5) hold_req = 1;
      for (int i = 0; i < 100; i++)
        send_base(16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, 65535)));
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
